// ===== hw/rtl/vow_pkg.sv =====
package vow_pkg;

  localparam int COORD_W     = 24;
  localparam int SHIFT_W     = 5;
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 16;
  // Point minus center plus half size needs two bits beyond the coordinate.
  localparam int REL_W       = 26;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_WINDOW = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_CENTER_Z   = 2'd2,
    CFG_CELL_SHIFT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_REL,
    ST_QUANT,
    ST_MUL1,
    ST_MUL2,
    ST_READ,
    ST_CLR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic en_rel;
    logic en_quant;
    logic en_mul1;
    logic en_mul2;
    logic rd;
    logic clr_wr;
    logic ins_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic clr_last;
  } sts_t;

endpackage

// ===== hw/rtl/vow_axis.sv =====
module vow_axis
  import vow_pkg::*;
#(
  parameter int CELLS = 16,
  localparam int IDX_W = $clog2(CELLS)
) (
  input  logic                      clk,
  input  logic                      rel_en,
  input  logic                      quant_en,
  input  logic signed [COORD_W-1:0] point,
  input  logic signed [COORD_W-1:0] center,
  input  logic        [SHIFT_W-1:0] shift,
  output logic        [IDX_W-1:0]   idx,
  output logic                      ok,
  output logic                      win_hit
);

  logic signed [REL_W-1:0] rel_r;
  logic signed [REL_W-1:0] half_r;
  logic        [SHIFT_W-1:0] sh_r;
  logic signed [REL_W-1:0] d;
  logic        [REL_W-1:0] q;
  logic                    ok_nxt;
  logic                    inside_nxt;
  logic        [IDX_W-1:0] idx_r;
  logic                    ok_r;
  logic                    inside_r;

  always_ff @(posedge clk) begin
    if (rel_en) begin
      rel_r  <= REL_W'(point) - REL_W'(center);
      half_r <= REL_W'(CELLS) << (shift - SHIFT_W'(1));
      sh_r   <= shift;
    end
  end

  // The offset from the window corner is never negative for a valid point,
  // so a logical shift gives the floor.
  always_comb begin
    d          = rel_r + half_r;
    q          = d >> sh_r;
    inside_nxt = (rel_r < half_r) && (rel_r > -half_r);
    ok_nxt     = !d[REL_W-1] && (q < REL_W'(CELLS));
  end

  always_ff @(posedge clk) begin
    if (quant_en) begin
      idx_r    <= ok_nxt ? q[IDX_W-1:0] : '0;
      ok_r     <= ok_nxt;
      inside_r <= inside_nxt;
    end
  end

  assign idx     = idx_r;
  assign ok      = ok_r;
  assign win_hit = inside_r;

endmodule

// ===== hw/rtl/vow_datapath.sv =====
module vow_datapath
  import vow_pkg::*;
#(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int VOXELS = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int ADDR_W = $clog2(VOXELS);
  localparam int IXW    = $clog2(CELLS_X);
  localparam int IYW    = $clog2(CELLS_Y);
  localparam int IZW    = $clog2(CELLS_Z);

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic        [SHIFT_W-1:0] cell_shift_r;
  logic        [SHIFT_W-1:0] eff_shift;

  op_t                       op_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;

  logic [IXW-1:0] ix;
  logic [IYW-1:0] iy;
  logic [IZW-1:0] iz;
  logic           okx, oky, okz;
  logic           wx, wy, wz;
  logic           valid;

  logic [ADDR_W-1:0] t_r;
  logic [ADDR_W-1:0] flat_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_last;
  logic              ins_we;
  logic              rd_bit_r;
  logic              occ;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic mem [VOXELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      center_z_r   <= '0;
      cell_shift_r <= SHIFT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:   center_x_r   <= cfg_wdata;
        CFG_CENTER_Y:   center_y_r   <= cfg_wdata;
        CFG_CENTER_Z:   center_z_r   <= cfg_wdata;
        CFG_CELL_SHIFT: cell_shift_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cell_shift_r < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (cell_shift_r > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = cell_shift_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= op_t'(in_tdata[OP_W-1:0]);
      px_r <= in_tdata[OP_W +: COORD_W];
      py_r <= in_tdata[OP_W+COORD_W +: COORD_W];
      pz_r <= in_tdata[OP_W+2*COORD_W +: COORD_W];
    end
  end

  vow_axis #(.CELLS(CELLS_X)) u_axis_x (
    .clk(clk), .rel_en(cmd.en_rel), .quant_en(cmd.en_quant),
    .point(px_r), .center(center_x_r), .shift(eff_shift),
    .idx(ix), .ok(okx), .win_hit(wx)
  );

  vow_axis #(.CELLS(CELLS_Y)) u_axis_y (
    .clk(clk), .rel_en(cmd.en_rel), .quant_en(cmd.en_quant),
    .point(py_r), .center(center_y_r), .shift(eff_shift),
    .idx(iy), .ok(oky), .win_hit(wy)
  );

  vow_axis #(.CELLS(CELLS_Z)) u_axis_z (
    .clk(clk), .rel_en(cmd.en_rel), .quant_en(cmd.en_quant),
    .point(pz_r), .center(center_z_r), .shift(eff_shift),
    .idx(iz), .ok(okz), .win_hit(wz)
  );

  assign valid = okx && oky && okz;

  // Flat index in two constant multiplies, one per stage.
  always_ff @(posedge clk) begin
    if (cmd.en_mul1) begin
      t_r <= ADDR_W'(iy) + ADDR_W'(CELLS_Y) * ADDR_W'(iz);
    end
    if (cmd.en_mul2) begin
      flat_r <= valid ? ADDR_W'(ix) + ADDR_W'(CELLS_X) * t_r : '0;
    end
  end

  assign clr_last = (clr_addr_r == ADDR_W'(VOXELS - 1));
  assign ins_we   = cmd.ins_wr && (op_r == OP_INSERT) && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (ins_we) begin
      mem[flat_r] <= 1'b1;
    end
    if (cmd.rd) begin
      rd_bit_r <= mem[flat_r];
    end
  end

  // An insert reports the bit it sets; a clear always reports zero.
  assign occ = valid && (op_r != OP_CLEAR) && ((op_r == OP_INSERT) || rd_bit_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {1'b0, wx && wy && wz, occ, INDEX_W'(flat_r), valid};
    end
  end

  assign out_tdata    = out_data_r;
  assign sts.op_clear = (op_r == OP_CLEAR);
  assign sts.clr_last = clr_last;

endmodule

// ===== hw/rtl/vow_ctrl.sv =====
module vow_ctrl
  import vow_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT_CLR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        cmd.en_rel = 1'b1;
        state_nxt  = ST_QUANT;
      end
      ST_QUANT: begin
        cmd.en_quant = 1'b1;
        state_nxt    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.en_mul1 = 1'b1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.en_mul2 = 1'b1;
        state_nxt   = sts.op_clear ? ST_CLR : ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // The store is updated in the same cycle the result is loaded.
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out = 1'b1;
          cmd.ins_wr   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ===== hw/rtl/voxel_occupancy_window.sv =====
// Sliding 3D occupancy window of single-bit voxels around a programmable center.
// Input requests on in_* carry an op (insert, query, window test, clear) and a
// point; each request produces exactly one result on out_*.
// The configuration port writes the center registers and the cell shift; write
// it only while no request is in flight. Moving the window is a center write
// followed by a clear request.
// A request is accepted in the idle state and then passes, before the next
// acceptance, through per-axis quantization (offset, then quantize), the two
// flat index multiplies, the store read and the load of the result register.
// A clear request instead of the store read sweeps the voxel store one bit per
// cycle, then loads its result.
// After reset the same sweep runs once over all CELLS_X*CELLS_Y*CELLS_Z bits (4096
// at the default size) with in_tready low; configuration writes are taken meanwhile.
// The result sits in an output register: a new request is accepted while it
// waits, and if the receiver still stalls when the next result is ready, the
// block holds in its last step until out_tready frees the register.
module voxel_occupancy_window
  import vow_pkg::*;
#(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // op[1:0], point_x[25:2], point_y[49:26], point_z[73:50], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // index_valid[0], cell_index[12:1], occupied[13], in_window[14], zero fill [15]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;

  vow_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  vow_datapath #(
    .CELLS_X (CELLS_X),
    .CELLS_Y (CELLS_Y),
    .CELLS_Z (CELLS_Z)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // No request may enter while the store is being swept.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_tready)
    else $error("request accepted during store sweep");

  // The sweep must never coincide with an insert or a store read on the store port.
  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && (cmd.ins_wr || cmd.rd)))
    else $error("store port conflict");

  // A result only appears right after the result register was loaded.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  // An accepted request starts its quantization in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.en_rel)
    else $error("accepted request not started");

endmodule

// ===== tb/sv/voxel_occupancy_window_test.sv =====
module voxel_occupancy_window_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vow_pkg::*;

  localparam int GRID           = 16;
  localparam int VOXELS         = GRID * GRID * GRID;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 250;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic               index_valid;
    logic [INDEX_W-1:0] cell_index;
    logic               occupied;
    logic               in_window;
  } voxel_result_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    logic               typed;
    voxel_result_t      want;
  } stim_row_t;

  // Rows with typed set carry a result that follows directly from the reset window
  // (center 0, edge 64 LSBs, half size 512); the rest go through the predictor.
  localparam stim_row_t DIRECTED [19] = '{
    '{OP_QUERY,  24'h000000, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2184, 1'b0, 1'b1}},
    '{OP_INSERT, 24'h000000, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2184, 1'b1, 1'b1}},
    '{OP_WINDOW, 24'h000000, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2184, 1'b1, 1'b1}},
    '{OP_INSERT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, '0},
    '{OP_INSERT, 24'h800000, 24'h800000, 24'h800000, 1'b1, '0},
    '{OP_QUERY,  24'hFFFE00, 24'hFFFE00, 24'hFFFE00, 1'b1, '{1'b1, 12'd0, 1'b0, 1'b0}},
    '{OP_INSERT, 24'h0001FF, 24'h0001FF, 24'h0001FF, 1'b1, '{1'b1, 12'd4095, 1'b1, 1'b1}},
    '{OP_QUERY,  24'h000200, 24'h000000, 24'h000000, 1'b1, '0},
    '{OP_QUERY,  24'hFFFDFF, 24'h000000, 24'h000000, 1'b1, '0},
    '{OP_WINDOW, 24'h000000, 24'h0001FF, 24'hFFFE01, 1'b1, '{1'b1, 12'd248, 1'b0, 1'b1}},
    '{OP_INSERT, 24'hFFFE00, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2176, 1'b1, 1'b0}},
    '{OP_QUERY,  24'h0001FF, 24'h0001FF, 24'h0001FF, 1'b1, '{1'b1, 12'd4095, 1'b1, 1'b1}},
    '{OP_CLEAR,  24'h000000, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2184, 1'b0, 1'b1}},
    '{OP_QUERY,  24'h000000, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2184, 1'b0, 1'b1}},
    '{OP_QUERY,  24'hFFFE00, 24'h000000, 24'h000000, 1'b1, '{1'b1, 12'd2176, 1'b0, 1'b0}},
    '{OP_CLEAR,  24'h7FFFFF, 24'h800000, 24'h000000, 1'b1, '0},
    '{OP_INSERT, 24'h000123, 24'hFFFF00, 24'h0001FF, 1'b0, '0},
    '{OP_WINDOW, 24'h000123, 24'hFFFF00, 24'h0001FF, 1'b0, '0},
    '{OP_QUERY,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Window settings and voxel bits as the block should hold them.
  logic [COORD_W-1:0] win_cx, win_cy, win_cz;
  logic [SHIFT_W-1:0] win_shift;
  bit                 voxel_map [VOXELS];

  voxel_result_t      pending_results [$];
  logic [3*COORD_W-1:0] recent_pts [16];
  int                 recent_n;
  int                 errors;
  int                 results_seen;
  int                 requests_sent;
  int                 clears_sent;
  int                 idle_cycles;
  int                 burst_left;
  bit                 drain_hold;

  voxel_occupancy_window #(
    .CELLS_X(GRID),
    .CELLS_Y(GRID),
    .CELLS_Z(GRID)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned cell_log2();
    if (win_shift < SHIFT_MIN) return int'(SHIFT_MIN);
    if (win_shift > SHIFT_MAX) return int'(SHIFT_MAX);
    return int'(win_shift);
  endfunction

  function automatic void locate_axis(input logic signed [COORD_W-1:0] p,
                                      input logic signed [COORD_W-1:0] c,
                                      input int unsigned sh, output bit ok,
                                      output longint idx, output bit near);
    longint half, rel, d;
    half = longint'(GRID) << (sh - 1);
    rel  = longint'(p) - longint'(c);
    d    = rel + half;
    near = (rel < half) && (rel > -half);
    idx  = (d < 0) ? 0 : (d >>> sh);
    ok   = (d >= 0) && (idx < GRID);
  endfunction

  function automatic voxel_result_t predict_voxel(input op_t op, input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py,
                                                  input logic [COORD_W-1:0] pz);
    int unsigned   sh;
    longint        ix, iy, iz;
    bit            okx, oky, okz, nx, ny, nz;
    voxel_result_t r;
    sh = cell_log2();
    locate_axis(px, win_cx, sh, okx, ix, nx);
    locate_axis(py, win_cy, sh, oky, iy, ny);
    locate_axis(pz, win_cz, sh, okz, iz, nz);
    r = '0;
    r.index_valid = okx && oky && okz;
    r.in_window   = nx && ny && nz;
    if (r.index_valid) r.cell_index = INDEX_W'(ix + GRID * (iy + GRID * iz));
    if (op == OP_CLEAR) begin
      foreach (voxel_map[i]) voxel_map[i] = 1'b0;
    end else if (r.index_valid) begin
      if (op == OP_INSERT) voxel_map[r.cell_index] = 1'b1;
      r.occupied = voxel_map[r.cell_index];
    end
    return r;
  endfunction

  // Mostly points around the window and its borders, some anywhere in the range.
  function automatic logic [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] c);
    longint      half, vox_len, off;
    int unsigned r;
    half = longint'(GRID) << (cell_log2() - 1);
    vox_len = longint'(1) << cell_log2();
    r = $urandom_range(0, 99);
    if (r < 6) return COORD_W'($urandom);
    if (r < 9) return (r == 6) ? 24'h7FFFFF : 24'h800000;
    if (r < 15) begin
      off = ($urandom_range(0, 1) == 1) ? half : -half;
      off = off + longint'($urandom_range(0, 2)) - 1;
      return COORD_W'(longint'(c) + off);
    end
    off = longint'($urandom_range(0, 32'(2 * half + 4 * vox_len))) - half - 2 * vox_len;
    return COORD_W'(longint'(c) + off);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer(input op_t op, input logic [COORD_W-1:0] px,
                       input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
                       input logic typed, input voxel_result_t want, input int gap);
    voxel_result_t pred;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({pz, py, px, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_voxel(op, px, py, pz);
    pending_results.push_back(typed ? want : pred);
    requests_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_CENTER_X:   win_cx = value;
      CFG_CENTER_Y:   win_cy = value;
      CFG_CENTER_Z:   win_cz = value;
      CFG_CELL_SHIFT: win_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the request line and wait until every result is back and the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin : receiver
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (drain_hold) begin
        drain_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        n = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    voxel_result_t got, want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.index_valid = out_tdata[0];
      got.cell_index  = out_tdata[12:1];
      got.occupied    = out_tdata[13];
      got.in_window   = out_tdata[14];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: cell_index %0d", got.cell_index);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.index_valid !== want.index_valid) begin
          $error("index_valid mismatch: expected %0d, got %0d",
                 want.index_valid, got.index_valid);
          errors++;
        end
        if (got.cell_index !== want.cell_index) begin
          $error("cell_index mismatch: expected %0d, got %0d", want.cell_index, got.cell_index);
          errors++;
        end
        if (got.occupied !== want.occupied) begin
          $error("occupied mismatch: expected %0d, got %0d", want.occupied, got.occupied);
          errors++;
        end
        if (got.in_window !== want.in_window) begin
          $error("in_window mismatch: expected %0d, got %0d", want.in_window, got.in_window);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int                    ph, k, rnd, gap;
    op_t                   op;
    logic [COORD_W-1:0]    px, py, pz, cx, cy, cz;
    logic [CFG_DATA_W-1:0] sw;
    errors        = 0;
    results_seen  = 0;
    requests_sent = 0;
    clears_sent   = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    recent_n      = 0;
    drain_hold    = 1'b0;
    win_cx        = '0;
    win_cy        = '0;
    win_cz        = '0;
    win_shift     = SHIFT_RESET;
    foreach (voxel_map[i]) voxel_map[i] = 1'b0;
    foreach (recent_pts[i]) recent_pts[i] = '0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_CENTER_X;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      offer(DIRECTED[i].op, DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].pz,
            DIRECTED[i].typed, DIRECTED[i].want, pick_gap());
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          cx = 24'h7FFFFF; cy = 24'h800000; cz = '0; sw = 24'd16;
        end
        1: begin
          cx = COORD_W'($urandom); cy = COORD_W'($urandom); cz = COORD_W'($urandom);
          sw = 24'd1;
        end
        2: begin
          cx = '0; cy = '0; cz = '0; sw = '0;
        end
        3: begin
          // Out-of-range shift with junk above the register width.
          cx = COORD_W'($urandom); cy = COORD_W'($urandom); cz = COORD_W'($urandom);
          sw = CFG_DATA_W'({19'($urandom), 5'd31});
        end
        4: begin
          cx = COORD_W'($urandom); cy = COORD_W'($urandom); cz = COORD_W'($urandom);
          sw = CFG_DATA_W'($urandom_range(2, 15));
        end
        default: begin
          cx = 24'h800000; cy = 24'h7FFFFF; cz = 24'h000100; sw = 24'd6;
        end
      endcase
      write_reg(CFG_CENTER_X, cx);
      write_reg(CFG_CENTER_Y, cy);
      write_reg(CFG_CENTER_Z, cz);
      write_reg(CFG_CELL_SHIFT, sw);
      cfg_wr_en <= 1'b0;
      offer(OP_CLEAR, win_cx, win_cy, win_cz, 1'b0, '0, 0);
      if (ph == 0) begin
        // Let the long clear sweep finish, then hold the result side off while
        // requests keep coming back to back.
        settle();
        drain_hold = 1'b1;
        burst_left = 60;
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        rnd = $urandom_range(0, 199);
        if (rnd == 0) op = OP_CLEAR;
        else if (rnd < 80) op = OP_INSERT;
        else if (rnd < 140) op = OP_QUERY;
        else op = OP_WINDOW;
        if (op != OP_INSERT && recent_n > 0 && $urandom_range(0, 1) == 1) begin
          {pz, py, px} = recent_pts[$urandom_range(0, (recent_n < 16 ? recent_n : 16) - 1)];
        end else begin
          px = pick_coord(win_cx);
          py = pick_coord(win_cy);
          pz = pick_coord(win_cz);
        end
        if (op == OP_INSERT) begin
          recent_pts[recent_n % 16] = {pz, py, px};
          recent_n++;
        end
        if (burst_left > 0) begin
          gap = 0;
          burst_left--;
        end else begin
          gap = pick_gap();
          if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
        end
        offer(op, px, py, pz, 1'b0, '0, gap);
      end
    end
    settle();

    $display("Checked %0d results for %0d requests, %0d of them clears, over %0d window settings.",
             results_seen, requests_sent, clears_sent, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
